### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the resampler checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CVR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CVR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/cvr_pkg.sv
// ----------------------------------------------------------------------------
// cvr_pkg
// Widths, command codes and shared types of the cubic varispeed resampler.
// ----------------------------------------------------------------------------
package cvr_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int FRAC_BITS   = 16;
	localparam int SPEED_BITS  = 20;
	localparam int MAX_OUT     = 64;

	localparam int TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int PHASE_BITS = SPEED_BITS + 1;
	localparam int CNT_BITS   = $clog2(MAX_OUT);

	// coefficient and accumulator widths
	localparam int A_W    = SAMPLE_BITS + 3;
	localparam int B_W    = SAMPLE_BITS + 4;
	localparam int C_W    = SAMPLE_BITS + 1;
	localparam int ACC_W  = SAMPLE_BITS + FRAC_BITS + 5;
	localparam int HS_W   = ACC_W - FRAC_BITS;
	localparam int SAT_W  = ACC_W - FRAC_BITS;

	localparam logic [SPEED_BITS-1:0] SPEED_RESET = SPEED_BITS'(64'd1 << FRAC_BITS);
	localparam logic [SPEED_BITS-1:0] SPEED_MIN   =
		SPEED_BITS'((64'd1 << FRAC_BITS) / MAX_OUT);
	localparam logic [PHASE_BITS-1:0] PHASE_ONE   = PHASE_BITS'(64'd1 << FRAC_BITS);

	localparam logic signed [SAT_W-1:0] SAT_MAX =
		SAT_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [SAT_W-1:0] SAT_MIN =
		SAT_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

	// datapath arithmetic ops
	localparam logic [2:0] DP_NOP  = 3'd0;
	localparam logic [2:0] DP_COEF = 3'd1;
	localparam logic [2:0] DP_U    = 3'd2;
	localparam logic [2:0] DP_HI   = 3'd3;
	localparam logic [2:0] DP_V    = 3'd4;
	localparam logic [2:0] DP_W    = 3'd5;
	localparam logic [2:0] DP_OUT  = 3'd6;

	// history updates
	localparam logic [2:0] HIST_NONE  = 3'd0;
	localparam logic [2:0] HIST_P0    = 3'd1;
	localparam logic [2:0] HIST_P1    = 3'd2;
	localparam logic [2:0] HIST_P2    = 3'd3;
	localparam logic [2:0] HIST_SHIFT = 3'd4;

	// phase updates
	localparam logic [2:0] PH_HOLD = 3'd0;
	localparam logic [2:0] PH_CLR  = 3'd1;
	localparam logic [2:0] PH_WRAP = 3'd2;
	localparam logic [2:0] PH_STEP = 3'd3;
	localparam logic [2:0] PH_END  = 3'd4;

	typedef struct packed {
		logic [2:0] dp_op;
		logic [2:0] hist_op;
		logic [2:0] ph_op;
		logic       last;
	} cvr_cmd_t;

	typedef struct packed {
		logic phase_ge_one;
		logic step_ge_one;
	} cvr_stat_t;

	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [SAT_W-1:0] v);
		logic signed [SAMPLE_BITS-1:0] r;
		if (v > SAT_MAX) begin
			r = SAT_MAX[SAMPLE_BITS-1:0];
		end else if (v < SAT_MIN) begin
			r = SAT_MIN[SAMPLE_BITS-1:0];
		end else begin
			r = v[SAMPLE_BITS-1:0];
		end
		return r;
	endfunction

endpackage

### rtl/cvr_dp.sv
// ----------------------------------------------------------------------------
// cvr_dp
// Datapath: speed register, sample history, phase, Hermite coefficients and
// the shared multiply/accumulate steps of the Horner evaluation.
// ----------------------------------------------------------------------------
module cvr_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr,
	input  logic [cvr_pkg::SPEED_BITS-1:0]       cfg_data,
	input  logic signed [cvr_pkg::SAMPLE_BITS-1:0] in_sample,
	input  cvr_pkg::cvr_cmd_t                    cmd,
	output cvr_pkg::cvr_stat_t                   stat,
	output logic signed [cvr_pkg::SAMPLE_BITS-1:0] out_sample,
	output logic                                 out_last
);
	import cvr_pkg::*;

	localparam int MA_W = A_W + FRAC_BITS + 1;
	localparam int MH_W = HS_W + FRAC_BITS + 1;

	logic [SPEED_BITS-1:0]        speed_q;
	logic [PHASE_BITS-1:0]        phase_q;
	logic signed [SAMPLE_BITS-1:0] hist_q [4];
	logic signed [A_W-1:0]        a_q;
	logic signed [B_W-1:0]        b_q;
	logic signed [C_W-1:0]        c_q;
	logic signed [ACC_W-1:0]      acc_q;
	logic signed [ACC_W-1:0]      hi_q;
	logic signed [SAMPLE_BITS-1:0] out_q;
	logic                         last_q;

	logic [SPEED_BITS-1:0]        spd_eff;
	logic [PHASE_BITS-1:0]        step;
	logic [FRAC_BITS-1:0]         t;
	logic signed [FRAC_BITS:0]    ts;
	logic signed [B_W-1:0]        z0e, z1e, z2e, z3e, d12;
	logic signed [B_W-1:0]        a_n, b_n;
	logic signed [C_W-1:0]        c_n;
	logic signed [MA_W-1:0]       mul_a;
	logic signed [MH_W-1:0]       mul_h;
	logic [2*FRAC_BITS-1:0]       mul_l;
	logic signed [ACC_W-1:0]      lo_e;
	logic signed [ACC_W-1:0]      u_n, v_n, w_n;
	logic signed [ACC_W:0]        y_sum;
	logic signed [SAT_W-1:0]      y_res;
	logic signed [SAT_W-1:0]      vp;

	assign spd_eff = (speed_q < SPEED_MIN) ? SPEED_MIN : speed_q;
	assign step    = phase_q + PHASE_BITS'(spd_eff);
	assign t       = phase_q[FRAC_BITS-1:0];
	assign ts      = $signed({1'b0, t});

	assign stat.phase_ge_one = (phase_q >= PHASE_ONE);
	assign stat.step_ge_one  = (step >= PHASE_ONE);

	// coefficients
	assign z0e = B_W'(hist_q[0]);
	assign z1e = B_W'(hist_q[1]);
	assign z2e = B_W'(hist_q[2]);
	assign z3e = B_W'(hist_q[3]);
	assign d12 = z1e - z2e;
	assign a_n = d12 + (d12 <<< 1) - z0e + z3e;
	assign b_n = (z2e <<< 2) + (z0e <<< 1) - ((z1e <<< 2) + z1e) - z3e;
	assign c_n = C_W'(hist_q[2]) - C_W'(hist_q[0]);

	// one multiplier per step
	assign mul_a = MA_W'(a_q) * MA_W'(ts);
	assign mul_h = MH_W'($signed(acc_q[ACC_W-1:FRAC_BITS])) * MH_W'(ts);
	assign mul_l = (2*FRAC_BITS)'(acc_q[FRAC_BITS-1:0]) * (2*FRAC_BITS)'(t);
	assign lo_e  = $signed({{(ACC_W-FRAC_BITS){1'b0}}, mul_l[2*FRAC_BITS-1:FRAC_BITS]});

	assign u_n = (ACC_W'(b_q) <<< FRAC_BITS) + ACC_W'(mul_a);
	assign v_n = (ACC_W'(c_q) <<< FRAC_BITS) + hi_q + lo_e;
	assign w_n = hi_q + lo_e;

	// round half up around z1
	assign y_sum = ((ACC_W+1)'(hist_q[1]) <<< (FRAC_BITS + 1)) + (ACC_W+1)'(acc_q)
		+ (ACC_W+1)'(64'sd1 <<< FRAC_BITS);
	assign y_res = $signed(y_sum[ACC_W:FRAC_BITS+1]);

	assign vp = (SAT_W'(hist_q[1]) <<< 1) - SAT_W'(in_sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= SPEED_RESET;
			phase_q <= '0;
		end else begin
			if (cfg_wr) begin
				speed_q <= cfg_data;
			end
			case (cmd.ph_op)
				PH_CLR:  phase_q <= '0;
				PH_WRAP: phase_q <= phase_q - PHASE_ONE;
				PH_STEP: phase_q <= step;
				PH_END:  phase_q <= stat.step_ge_one ? (step - PHASE_ONE) : '0;
				default: phase_q <= phase_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.hist_op)
			HIST_P0: hist_q[1] <= in_sample;
			HIST_P1: begin
				hist_q[0] <= sat_sample(vp);
				hist_q[2] <= in_sample;
			end
			HIST_P2: hist_q[3] <= in_sample;
			HIST_SHIFT: begin
				hist_q[0] <= hist_q[1];
				hist_q[1] <= hist_q[2];
				hist_q[2] <= hist_q[3];
				hist_q[3] <= in_sample;
			end
			default: ;
		endcase

		case (cmd.dp_op)
			DP_COEF: begin
				a_q <= A_W'(a_n);
				b_q <= b_n;
				c_q <= c_n;
			end
			DP_U:  acc_q <= u_n;
			DP_HI: hi_q  <= ACC_W'(mul_h);
			DP_V:  acc_q <= v_n;
			DP_W:  acc_q <= w_n;
			DP_OUT: begin
				out_q  <= sat_sample(y_res);
				last_q <= cmd.last;
			end
			default: ;
		endcase
	end

	assign out_sample = out_q;
	assign out_last   = last_q;

endmodule

### rtl/cvr_ctrl.sv
// ----------------------------------------------------------------------------
// cvr_ctrl
// Controller: priming count, output count, step sequence and the output
// register's valid flag.
// ----------------------------------------------------------------------------
module cvr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tuser,
	output logic                s_tready,
	input  logic                m_tready,
	output logic                m_tvalid,
	output cvr_pkg::cvr_cmd_t   cmd,
	input  cvr_pkg::cvr_stat_t  stat
);
	import cvr_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_COEF = 3'd1;
	localparam logic [2:0] ST_U    = 3'd2;
	localparam logic [2:0] ST_HV   = 3'd3;
	localparam logic [2:0] ST_LV   = 3'd4;
	localparam logic [2:0] ST_HW   = 3'd5;
	localparam logic [2:0] ST_LW   = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	localparam logic [1:0] PRIME_NONE = 2'd0;
	localparam logic [1:0] PRIME_ONE  = 2'd1;
	localparam logic [1:0] PRIME_TWO  = 2'd2;
	localparam logic [1:0] PRIME_FULL = 2'd3;

	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(MAX_OUT - 1);

	logic [2:0]          state_q, state_n;
	logic [1:0]          primed_q, primed_n, primed_eff;
	logic [CNT_BITS-1:0] cnt_q, cnt_n;
	logic                out_valid_q;
	logic                accept;
	logic                out_free;
	logic                last;

	assign s_tready   = (state_q == ST_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign primed_eff = s_tuser ? PRIME_NONE : primed_q;
	assign out_free   = !out_valid_q || m_tready;
	assign last       = stat.step_ge_one || (cnt_q == CNT_LAST);
	assign m_tvalid   = out_valid_q;

	always_comb begin
		state_n     = state_q;
		primed_n    = primed_q;
		cnt_n       = cnt_q;
		cmd.dp_op   = DP_NOP;
		cmd.hist_op = HIST_NONE;
		cmd.ph_op   = PH_HOLD;
		cmd.last    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser) begin
						cmd.ph_op = PH_CLR;
					end
					case (primed_eff)
						PRIME_NONE: begin
							cmd.hist_op = HIST_P0;
							primed_n    = PRIME_ONE;
						end
						PRIME_ONE: begin
							cmd.hist_op = HIST_P1;
							primed_n    = PRIME_TWO;
						end
						PRIME_TWO: begin
							cmd.hist_op = HIST_P2;
							primed_n    = PRIME_FULL;
							state_n     = ST_COEF;
						end
						default: begin
							cmd.hist_op = HIST_SHIFT;
							primed_n    = PRIME_FULL;
							state_n     = ST_COEF;
						end
					endcase
				end
			end
			ST_COEF: begin
				cmd.dp_op = DP_COEF;
				if (stat.phase_ge_one) begin
					cmd.ph_op = PH_WRAP;
					state_n   = ST_IDLE;
				end else begin
					cnt_n   = '0;
					state_n = ST_U;
				end
			end
			ST_U: begin
				cmd.dp_op = DP_U;
				state_n   = ST_HV;
			end
			ST_HV: begin
				cmd.dp_op = DP_HI;
				state_n   = ST_LV;
			end
			ST_LV: begin
				cmd.dp_op = DP_V;
				state_n   = ST_HW;
			end
			ST_HW: begin
				cmd.dp_op = DP_HI;
				state_n   = ST_LW;
			end
			ST_LW: begin
				cmd.dp_op = DP_W;
				state_n   = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.dp_op = DP_OUT;
					cmd.last  = last;
					cmd.ph_op = last ? PH_END : PH_STEP;
					cnt_n     = cnt_q + 1'b1;
					state_n   = last ? ST_IDLE : ST_U;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			primed_q    <= PRIME_NONE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			primed_q <= primed_n;
			cnt_q    <= cnt_n;
			if (cmd.dp_op == DP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/cubic_varispeed_resampler.sv
// Sequence: a priming input, or one arriving with the phase at or past one, is done
//   after the accept or coefficient step and gives no result. Otherwise the accept
//   and coefficient steps lead to six steps per result (n <= 64): U, HV, LV, HW, LW, OUT.
//   OUT waits while the output is stalled; no new input is taken before the run ends.
// Reset: arst_n clears the controller, priming, phase and the output valid
//   flag at once; speed returns to 1.0 (Q4.16 0x10000).
// ----------------------------------------------------------------------------
// cubic_varispeed_resampler
// Four-point cubic Hermite resampler with a programmable playback speed.
// ----------------------------------------------------------------------------
module cubic_varispeed_resampler (
	input  logic                               clk,
	input  logic                               arst_n,
	// speed register write channel, Q4.16
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cvr_pkg::SPEED_BITS-1:0]     cfg_data,
	// input samples
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [cvr_pkg::TDATA_W-1:0]        s_tdata,   // [23:0] in_sample
	input  logic                               s_tuser,   // [0] restart
	// resampled output
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [cvr_pkg::TDATA_W-1:0]        m_tdata,   // [23:0] out_sample
	output logic                               m_tlast    // last_of_run
);
	import cvr_pkg::*;

	cvr_cmd_t                      cmd;
	cvr_stat_t                     stat;
	logic signed [SAMPLE_BITS-1:0] in_sample;
	logic signed [SAMPLE_BITS-1:0] out_sample;

	// speed writes are taken any cycle; software must only write while idle, the block does not enforce it
	assign cfg_ready = 1'b1;
	assign in_sample = $signed(s_tdata[SAMPLE_BITS-1:0]);
	assign m_tdata   = TDATA_W'($unsigned(out_sample));

	// Controller: priming, per-input output count, six-step Horner sequence.
	cvr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.cmd      (cmd),
		.stat     (stat)
	);

	// Datapath: history window, phase accumulator, coefficients, MAC steps,
	// and the output register that lets the next result build while this
	// one waits.
	cvr_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg_valid & cfg_ready),
		.cfg_data   (cfg_data),
		.in_sample  (in_sample),
		.cmd        (cmd),
		.stat       (stat),
		.out_sample (out_sample),
		.out_last   (m_tlast)
	);

endmodule

### rtl/cvr_checker.sv
// ----------------------------------------------------------------------------
// cvr_checker
// Port-level checks of the resampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cvr_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         s_tuser,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [cvr_pkg::TDATA_W-1:0]  m_tdata,
	input logic                         m_tlast
);

	// stalled result holds
	`CVR_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")

	// a restart sample only primes, so input stays open
	`CVR_ASSERT_NEXT(a_restart_idle, clk, arst_n, s_tvalid && s_tready && s_tuser, s_tready, "restart sample did not return to idle")

	// a new result is only produced while the input side is busy
	`CVR_ASSERT_NOW(a_rise_busy, clk, arst_n, $rose(m_tvalid), $past(!s_tready), "result appeared while idle")

	// an input is not taken before its run of results ends
	`CVR_ASSERT_NOW(a_run_busy, clk, arst_n, m_tvalid && m_tready && !m_tlast, !s_tready, "input open in the middle of a run")

endmodule

bind cubic_varispeed_resampler cvr_checker u_cvr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cubic varispeed resampler. Samples go in on the
// slave stream and interpolated samples are compared against a cycle-free
// Hermite predictor. Runs a directed table, then random phases at many speeds.
// ----------------------------------------------------------------------------
module tb;

	import cvr_pkg::*;

	localparam int          SB       = SAMPLE_BITS;
	localparam int          FRAC     = FRAC_BITS;
	localparam int unsigned ONE_U    = 32'd1 << FRAC;
	localparam int unsigned SPD_FLOOR = ONE_U / MAX_OUT;
	localparam logic signed [95:0] ONE96  = 96'sd1 <<< FRAC;
	localparam logic signed [95:0] SMAX96 = (96'sd1 <<< (SB - 1)) - 96'sd1;
	localparam logic signed [95:0] SMIN96 = -(96'sd1 <<< (SB - 1));

	localparam int SETTLE      = 16;      // idle cycles after the last result
	localparam int HOLD_CYCLES = 300;     // long receiver hold-off
	localparam int N_DIR       = 24;
	localparam int N_PHASE     = 10;

	// how a directed row is checked
	localparam logic [1:0] EXP_MODEL = 2'd0;  // predictor decides
	localparam logic [1:0] EXP_NONE  = 2'd1;  // no output
	localparam logic [1:0] EXP_ONE   = 2'd2;  // exactly one output, value typed

	typedef struct packed {
		logic [SB-1:0] smp;
		logic          last;
	} outres_t;

	typedef struct packed {
		logic                  set_spd;
		logic [SPEED_BITS-1:0] spd;
		logic                  rst;
		logic [SB-1:0]         smp;
		logic [1:0]            chk;
		logic [SB-1:0]         val;
	} dir_row_t;

	// At speed 1.0 the phase is always zero, so each output is z1: the sample
	// two inputs back (or the first sample of the run for the first output).
	localparam dir_row_t DIR_TAB [0:N_DIR-1] = '{
		'{1'b0, 20'd0,       1'b0, 24'h7FFFFF, EXP_NONE,  24'h0},
		'{1'b0, 20'd0,       1'b0, 24'h800000, EXP_NONE,  24'h0},  // virtual point clips high
		'{1'b0, 20'd0,       1'b0, 24'h000000, EXP_ONE,   24'h7FFFFF},
		'{1'b0, 20'd0,       1'b0, 24'h123456, EXP_ONE,   24'h800000},
		'{1'b0, 20'd0,       1'b0, 24'hFFFFFF, EXP_ONE,   24'h000000},
		'{1'b0, 20'd0,       1'b1, 24'h800000, EXP_NONE,  24'h0},
		'{1'b0, 20'd0,       1'b0, 24'h7FFFFF, EXP_NONE,  24'h0},  // virtual point clips low
		'{1'b0, 20'd0,       1'b0, 24'h000001, EXP_ONE,   24'h800000},
		'{1'b0, 20'd0,       1'b0, 24'h555555, EXP_ONE,   24'h7FFFFF},
		'{1'b0, 20'd0,       1'b0, 24'hAAAAAA, EXP_ONE,   24'h000001},
		// speed zero falls back to the 1/64 floor: 64 outputs per input
		'{1'b1, 20'd0,       1'b1, 24'h7FFFFF, EXP_NONE,  24'h0},
		'{1'b0, 20'd0,       1'b0, 24'h800000, EXP_NONE,  24'h0},
		'{1'b0, 20'd0,       1'b0, 24'h7FFFFF, EXP_MODEL, 24'h0},
		'{1'b0, 20'd0,       1'b0, 24'h800000, EXP_MODEL, 24'h0},
		// max speed: phase overruns, most inputs only slide the window
		'{1'b1, 20'hFFFFF,   1'b0, 24'h400000, EXP_MODEL, 24'h0},
		'{1'b0, 20'd0,       1'b0, 24'hC00000, EXP_MODEL, 24'h0},
		'{1'b0, 20'd0,       1'b0, 24'h000000, EXP_MODEL, 24'h0},
		// just under the floor
		'{1'b1, 20'd1023,    1'b0, 24'h3FFFFF, EXP_MODEL, 24'h0},
		'{1'b1, 20'd98304,   1'b1, 24'h100000, EXP_NONE,  24'h0},
		'{1'b0, 20'd0,       1'b0, 24'hF00000, EXP_NONE,  24'h0},
		'{1'b0, 20'd0,       1'b0, 24'h080000, EXP_MODEL, 24'h0},
		'{1'b0, 20'd0,       1'b0, 24'hFFFFFF, EXP_MODEL, 24'h0},
		'{1'b0, 20'd0,       1'b0, 24'h000001, EXP_MODEL, 24'h0},
		'{1'b1, 20'd65536,   1'b1, 24'h7FFFFF, EXP_NONE,  24'h0}
	};

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [SPEED_BITS-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [TDATA_W-1:0]    s_tdata   = '0;   // [23:0] in_sample
	logic                  s_tuser   = 1'b0; // [0] restart
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [TDATA_W-1:0]    m_tdata;          // [23:0] out_sample
	logic                  m_tlast;          // last_of_run

	cubic_varispeed_resampler u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// predictor state
	logic signed [95:0]    win [0:3];
	int unsigned           primed   = 0;
	int unsigned           ph       = 0;
	logic [SPEED_BITS-1:0] speed_q  = SPEED_BITS'(ONE_U);

	outres_t pending_outputs [$];

	// stimulus bookkeeping
	int walk        = 0;
	int flood_left  = 0;
	bit src_steady  = 1'b0;
	bit sink_steady = 1'b0;
	bit hold_req    = 1'b0;

	int n_inputs    = 0;
	int n_restarts  = 0;
	int n_predicted = 0;
	int n_checked   = 0;
	int n_speeds    = 0;
	int n_err       = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [SB-1:0] clip_sample(input logic signed [95:0] y);
		if (y > SMAX96)
			return SMAX96[SB-1:0];
		if (y < SMIN96)
			return SMIN96[SB-1:0];
		return y[SB-1:0];
	endfunction

	// cubic Hermite point at phase t (Q0.16) between win[1] and win[2]
	function automatic logic [SB-1:0] hermite_point(input int unsigned t_in);
		logic signed [95:0] z0, z1, z2, z3, t, ca, cb, cc, u, v, w, y;
		z0 = win[0];
		z1 = win[1];
		z2 = win[2];
		z3 = win[3];
		t  = t_in;
		ca = 3 * (z1 - z2) - z0 + z3;
		cb = 4 * z2 + 2 * z0 - 5 * z1 - z3;
		cc = z2 - z0;
		u  = cb * ONE96 + ca * t;
		v  = cc * ONE96 + ((u * t) >>> FRAC);
		w  = (v * t) >>> FRAC;
		y  = (2 * z1 * ONE96 + w + ONE96) >>> (FRAC + 1);
		return clip_sample(y);
	endfunction

	// advance the predictor by one input; keep=0 updates state only
	function automatic void predict_input(input logic [SB-1:0] smp, input logic rst,
		input bit keep);
		logic signed [95:0] x;
		int unsigned        spd;
		int                 n;
		outres_t            r;
		x = $signed(smp);
		n = 0;
		if (rst) begin
			primed = 0;
			ph     = 0;
		end
		if (primed == 0) begin
			win[1] = x;
			primed = 1;
		end else if (primed == 1) begin
			win[0] = $signed(clip_sample(2 * win[1] - x));
			win[2] = x;
			primed = 2;
		end else begin
			if (primed == 2) begin
				win[3] = x;
			end else begin
				win[0] = win[1];
				win[1] = win[2];
				win[2] = win[3];
				win[3] = x;
			end
			primed = 3;
			spd = speed_q;
			if (spd < SPD_FLOOR)
				spd = SPD_FLOOR;
			while (ph < ONE_U && n < MAX_OUT) begin
				r.smp  = hermite_point(ph);
				ph     = ph + spd;
				n++;
				r.last = !(ph < ONE_U && n < MAX_OUT);
				if (keep)
					pending_outputs.push_back(r);
			end
			if (ph >= ONE_U)
				ph = ph - ONE_U;
			else
				ph = 0;
			n_predicted += n;
		end
	endfunction

	function automatic int src_gap();
		if (flood_left > 0) begin
			flood_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			src_steady = !src_steady;
		return src_steady ? 0 : $urandom_range(0, 13);
	endfunction

	function automatic int sink_gap();
		if ($urandom_range(0, 15) == 0)
			sink_steady = !sink_steady;
		return sink_steady ? 0 : $urandom_range(0, 13);
	endfunction

	// mix of full-scale noise, rail values and a smooth random walk
	function automatic logic [SB-1:0] pick_sample();
		logic [SB-1:0] r;
		int            step;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0:       r = 24'h7FFFFF;
					1:       r = 24'h800000;
					2:       r = 24'h000000;
					default: r = 24'hFFFFFF;
				endcase
			end
			1, 2: begin
				r = SB'($urandom());
			end
			default: begin
				step = int'($urandom_range(0, 400000)) - 200000;
				walk = walk + step;
				if (walk > 8388607)
					walk = 8388607;
				if (walk < -8388608)
					walk = -8388608;
				r = SB'(walk);
			end
		endcase
		walk = int'($signed(r));
		return r;
	endfunction

	// one input transaction; leaves s_tvalid high so back-to-back items stay gapless
	task automatic send_input(input logic [SB-1:0] smp, input logic rst, input bit keep);
		int gap;
		gap = src_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= TDATA_W'(smp);
		s_tuser  <= rst;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_input(smp, rst, keep);
		n_inputs++;
		if (rst)
			n_restarts++;
	endtask

	// stop offering and wait for every expected output, plus slack for
	// inputs that produce nothing
	task automatic drain_outputs();
		s_tvalid <= 1'b0;
		while (pending_outputs.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_speed(input logic [SPEED_BITS-1:0] v);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		speed_q = v;
		n_speeds++;
	endtask

	// output sink with random stalls and one long hold-off on request
	initial begin : sink
		int w;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			w = sink_gap();
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!(m_tvalid && m_tready)) @(posedge clk);
		end
	end

	// output checker
	always @(posedge clk) begin : check
		outres_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_outputs.size() == 0) begin
				$error("unexpected output transaction: out_sample %h last_of_run %b",
					m_tdata[SB-1:0], m_tlast);
				n_err++;
			end else begin
				want = pending_outputs.pop_front();
				n_checked++;
				if (m_tdata[SB-1:0] !== want.smp) begin
					$error("out_sample: expected %h, got %h", want.smp, m_tdata[SB-1:0]);
					n_err++;
				end
				if (m_tlast !== want.last) begin
					$error("last_of_run: expected %b, got %b", want.last, m_tlast);
					n_err++;
				end
			end
		end
	end

	initial begin : stim
		dir_row_t    row;
		outres_t     r;
		int unsigned plan_lo [N_PHASE];
		int unsigned plan_hi [N_PHASE];
		int          plan_len [N_PHASE];
		int          guard;
		logic        rst;

		for (int k = 0; k < 4; k++)
			win[k] = '0;

		// speed ranges and item counts per random phase
		plan_lo  = '{65536, 1024, 32768, 98304, 1024,   524288, 20'hFFFFF, 1023, 0,
			40000};
		plan_hi  = '{65536, 1024, 32768, 98304, 131072, 524288, 20'hFFFFF, 1023,
			20'hFFFFF, 300000};
		plan_len = '{60, 15, 50, 50, 50, 60, 60, 10, 50, 65};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < N_DIR; i++) begin
			row = DIR_TAB[i];
			if (row.set_spd) begin
				drain_outputs();
				write_speed(row.spd);
			end
			send_input(row.smp, row.rst, row.chk == EXP_MODEL);
			if (row.chk == EXP_ONE) begin
				r.smp  = row.val;
				r.last = 1'b1;
				pending_outputs.push_back(r);
			end
		end

		// random phases, each at its own speed
		for (int p = 0; p < N_PHASE; p++) begin
			drain_outputs();
			write_speed(SPEED_BITS'($urandom_range(plan_lo[p], plan_hi[p])));
			for (int k = 0; k < plan_len[p]; k++) begin
				if (p == 0 && k == 10) begin
					// receiver stops for a long stretch while inputs keep coming
					hold_req   = 1'b1;
					flood_left = 40;
				end
				if (p == 2 && k == 25)
					drain_outputs();
				rst = (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 31) == 0);
				send_input(pick_sample(), rst, 1'b1);
			end
		end

		s_tvalid <= 1'b0;
		guard = 0;
		while (pending_outputs.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE) @(posedge clk);
		if (pending_outputs.size() != 0) begin
			$error("%0d expected output transactions never arrived", pending_outputs.size());
			n_err++;
		end

		$display("Fed %0d samples (%0d restarts) through %0d speed writes, from zero to full scale.",
			n_inputs, n_restarts, n_speeds);
		$display("Compared %0d interpolated outputs of %0d predicted; %0d mismatches.",
			n_checked, n_predicted, n_err);
		if (n_err == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### cubic_varispeed_resampler.f
+incdir+rtl
rtl/cvr_pkg.sv
rtl/cvr_dp.sv
rtl/cvr_ctrl.sv
rtl/cubic_varispeed_resampler.sv
rtl/cvr_checker.sv
dv/tb.sv
